/* hdl/mawcb_pkg.sv */
// Package: mode codes, register map and reset values for the mode arbiter.
`timescale 1ns / 1ps
package mawcb_pkg;

	localparam int unsigned NUM_MODES  = 3;
	localparam int unsigned TIME_W     = 40;
	localparam int unsigned TOTAL_W    = 32;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_MOVE   = 2'd0,
		MODE_ATTACK = 2'd1,
		MODE_DEFEND = 2'd2
	} mode_t;

	// Register index, taken from paddr[2]
	typedef enum logic {
		REG_COOLDOWN = 1'b0,
		REG_LIMIT    = 1'b1
	} reg_idx_t;

	localparam logic [TOTAL_W-1:0] COOLDOWN_RST = 32'd5000;
	localparam logic [TOTAL_W-1:0] LIMIT_RST    = 32'd180000;

	// Code three has no meaning: treat as defend
	function automatic mode_t clamp_mode(input logic [MODE_W-1:0] m);
		mode_t r;
		case (m)
			MODE_MOVE:   r = MODE_MOVE;
			MODE_ATTACK: r = MODE_ATTACK;
			default:     r = MODE_DEFEND;
		endcase
		return r;
	endfunction

endpackage

/* hdl/mawcb_tick_if.sv */
// Interface: input tick channel (timestamp, requested mode, running flag).
`timescale 1ns / 1ps
interface mawcb_tick_if;
	import mawcb_pkg::*;

	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   now_ms;
	logic [MODE_W-1:0]   want_mode;
	logic                live;

	modport source (output valid, output now_ms, output want_mode,
		output live, input ready);
	modport sink (input valid, input now_ms, input want_mode,
		input live, output ready);
endinterface

/* hdl/mawcb_grant_if.sv */
// Interface: result channel (granted mode, switch flag).
`timescale 1ns / 1ps
interface mawcb_grant_if;
	import mawcb_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   granted_mode;
	logic                switched;

	modport source (output valid, output granted_mode, output switched, input ready);
	modport sink (input valid, input granted_mode, input switched, output ready);
endinterface

/* hdl/mode_arbiter_with_cooldown_and_budget_top.sv */
// Mode arbiter with switch cooldown and per-mode usage budget.
//
// Usage:
//   tick  (sink):   one word per timestamp: now_ms, want_mode, live (match running).
//   grant (source): one word per tick: granted_mode and switched.
//   APB:            register 0 at 0x0 is cooldown_ms (reset 5000), register 1
//                   at 0x4 is usage_limit_ms (reset 180000). Write only while idle.
// Latency: the grant word for a tick is valid the cycle after the tick is taken
//   when no older grant waits in the buffer.
// Throughput: one tick per cycle unless stalled. The whole update (elapsed time,
//   saturating budget add, limit compares, mode pick and cooldown check) is one
//   combinational pass from the arbiter state registers back into themselves.
// Stall: results sit in a two-word buffer (head plus skid); tick.ready drops
//   only when both words are full, so a tick is still taken while one grant
//   waits for the receiver.
// Reset: arst_n clears the session flag, the active mode (move), both
//   buffer slots and restores the register defaults. The first tick after
//   reset opens a new session, so the timers need no reset value.
`timescale 1ns / 1ps
module mode_arbiter_with_cooldown_and_budget_top (
	input  logic                              clk,
	input  logic                              arst_n,
	mawcb_tick_if.sink                        tick,
	mawcb_grant_if.source                     grant,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mawcb_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [mawcb_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mawcb_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready
);
	import mawcb_pkg::*;

	// Configuration registers
	logic [TOTAL_W-1:0] cooldown_q;
	logic [TOTAL_W-1:0] limit_q;
	reg_idx_t           reg_sel;

	// Arbiter state
	logic               started_q;
	logic               was_running_q;
	mode_t              cur_q;
	logic [TIME_W-1:0]  last_upd_q;
	logic [TIME_W:0]    last_sw_q;     // signed, two's complement
	logic [TOTAL_W-1:0] tot_q [NUM_MODES];

	// Output buffer
	logic               head_valid_q;
	mode_t              head_mode_q;
	logic               head_sw_q;
	logic               skid_valid_q;
	mode_t              skid_mode_q;
	logic               skid_sw_q;

	// Combinational update
	logic               accept;
	logic               pop;
	logic               sess;
	mode_t              req;
	mode_t              mode_a;
	logic [TIME_W-1:0]  now;
	logic               step_neg;
	logic [TIME_W-1:0]  step;
	logic [TOTAL_W:0]   add_sum;
	logic               add_sat;
	logic [TOTAL_W-1:0] tot_n [NUM_MODES];
	logic [NUM_MODES-1:0] free;
	logic [TIME_W:0]    last_sw_a;
	logic [TIME_W:0]    last_sw_n;
	logic [TIME_W+1:0]  since;
	logic               cool_ok;
	mode_t              res;
	logic               sw;

	// APB: always ready, decode on paddr[2]
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_comb begin
		case (reg_sel)
			REG_COOLDOWN: prdata = cooldown_q;
			REG_LIMIT:    prdata = limit_q;
			default:      prdata = cooldown_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RST;
			limit_q    <= LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_COOLDOWN: cooldown_q <= pwdata;
				REG_LIMIT:    limit_q    <= pwdata;
				default:      ;
			endcase
		end
	end

	// Handshakes: take a tick unless the skid slot is occupied
	assign tick.ready = !skid_valid_q;
	assign accept     = tick.valid && tick.ready;
	assign pop        = head_valid_q && grant.ready;

	always_comb begin
		now  = tick.now_ms;
		req  = clamp_mode(tick.want_mode);
		// New session on first tick or on a rise of the running flag
		sess = !started_q || (!was_running_q && tick.live);

		// Elapsed time, clamped at zero when time runs backwards
		step_neg = now < last_upd_q;
		step     = now - last_upd_q;
		add_sum  = {1'b0, tot_q[cur_q]} + {1'b0, step[TOTAL_W-1:0]};
		add_sat  = (|step[TIME_W-1:TOTAL_W]) || add_sum[TOTAL_W];

		for (int i = 0; i < NUM_MODES; i++) begin
			if (sess) begin
				tot_n[i] = '0;
			end else if (was_running_q && !step_neg && (cur_q == mode_t'(i))) begin
				tot_n[i] = add_sat ? '1 : add_sum[TOTAL_W-1:0];
			end else begin
				tot_n[i] = tot_q[i];
			end
			free[i] = tot_n[i] < limit_q;
		end

		mode_a    = sess ? MODE_MOVE : cur_q;
		// Session start backdates the last switch so a switch is allowed at once
		last_sw_a = sess ? ({1'b0, now} - {{(TIME_W+1-TOTAL_W){1'b0}}, cooldown_q})
		                 : last_sw_q;
		since     = {2'b00, now} - {last_sw_a[TIME_W], last_sw_a};
		cool_ok   = !since[TIME_W+1] &&
		            (since[TIME_W:0] >= {{(TIME_W+1-TOTAL_W){1'b0}}, cooldown_q});

		if (!free[mode_a]) begin
			// Active mode spent: first free of requested/move/attack/defend, else move
			if (free[req]) begin
				res = req;
			end else if (free[MODE_MOVE]) begin
				res = MODE_MOVE;
			end else if (free[MODE_ATTACK]) begin
				res = MODE_ATTACK;
			end else if (free[MODE_DEFEND]) begin
				res = MODE_DEFEND;
			end else begin
				res = MODE_MOVE;
			end
		end else if (free[req] && (req != mode_a) && cool_ok) begin
			res = req;
		end else begin
			res = mode_a;
		end

		sw        = res != cur_q;
		last_sw_n = (res != mode_a) ? {1'b0, now} : last_sw_a;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q     <= 1'b0;
			was_running_q <= 1'b0;
			cur_q         <= MODE_MOVE;
		end else if (accept) begin
			started_q     <= 1'b1;
			was_running_q <= tick.live;
			cur_q         <= res;
		end
	end

	// Timers and totals: a fresh session overwrites them, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			last_upd_q <= now;
			last_sw_q  <= last_sw_n;
			for (int i = 0; i < NUM_MODES; i++) begin
				tot_q[i] <= tot_n[i];
			end
		end
	end

	// Two-word result buffer: head drives the port, skid holds the overflow word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				head_valid_q <= accept;
			end
		end else if (accept) begin
			if (!head_valid_q) begin
				head_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_mode_q <= skid_mode_q;
				head_sw_q   <= skid_sw_q;
			end else begin
				head_mode_q <= res;
				head_sw_q   <= sw;
			end
		end else if (accept) begin
			if (!head_valid_q) begin
				head_mode_q <= res;
				head_sw_q   <= sw;
			end else begin
				skid_mode_q <= res;
				skid_sw_q   <= sw;
			end
		end
	end

	assign grant.valid        = head_valid_q;
	assign grant.granted_mode = head_mode_q;
	assign grant.switched     = head_sw_q;

endmodule

/* bench/tb_mode_arbiter_with_cooldown_and_budget_top.sv */
// Testbench for the mode arbiter: directed and random ticks checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb_mode_arbiter_with_cooldown_and_budget_top;
	import mawcb_pkg::*;

	// Cycles with no word moving on either channel before the run is called hung
	localparam int WATCHDOG_LIMIT = 2000;
	// Mode code three has no meaning in the block; it must behave as defend
	localparam logic [MODE_W-1:0] MODE_CODE_SPARE = 2'd3;
	localparam logic [TIME_W-1:0] STAMP_MAX = 40'hFF_FFFF_FFFF;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [MODE_W-1:0] want_mode;
		logic              live;
	} tick_word_t;

	typedef struct packed {
		mode_t granted_mode;
		logic  switched;
	} grant_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mawcb_tick_if  tick_bus ();
	mawcb_grant_if grant_bus ();

	mode_arbiter_with_cooldown_and_budget_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_bus),
		.grant   (grant_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Words waiting to be offered, and grants still owed by the block
	tick_word_t  tick_pending[$];
	grant_word_t grant_owed[$];

	int unsigned src_idle_pct;
	int unsigned rx_stall_pct;
	int          rx_hold_left;
	int          error_count;
	int          quiet_cycles;

	// Random stream state: timestamp cursor and running flag
	logic [TIME_W-1:0] stamp;
	logic              run_flag;

	// Predictor copy of the arbiter state and its two registers
	logic [TOTAL_W-1:0] cooldown_cfg;
	logic [TOTAL_W-1:0] limit_cfg;
	logic               sess_open;
	logic               prev_running;
	mode_t              pred_mode;
	logic [TIME_W-1:0]  last_tick_ms;
	longint             last_switch_ms;
	logic [TOTAL_W-1:0] mode_usage [NUM_MODES];

	tick_word_t tick_next;
	tick_word_t tick_taken;
	grant_word_t grant_due;

	function automatic mode_t decode_mode(logic [MODE_W-1:0] code);
		return (code > MODE_DEFEND) ? MODE_DEFEND : mode_t'(code);
	endfunction

	function automatic bit has_budget(mode_t m);
		return mode_usage[m] < limit_cfg;
	endfunction

	// Advance the predicted arbiter by one tick and return the grant it owes
	function automatic grant_word_t resolve_tick(tick_word_t t);
		mode_t       req;
		mode_t       held;
		mode_t       pick;
		mode_t       order [5];
		longint      elapsed;
		longint      since;
		longint      sum;
		bit          found;
		grant_word_t g;
		req = decode_mode(t.want_mode);
		held = pred_mode;
		if (!sess_open || (!prev_running && t.live)) begin
			// New session: clear budgets, fall back to move, cooldown already over
			sess_open = 1'b1;
			prev_running = t.live;
			pred_mode = MODE_MOVE;
			last_tick_ms = t.now_ms;
			last_switch_ms = longint'(t.now_ms) - longint'(cooldown_cfg);
			for (int i = 0; i < NUM_MODES; i++)
				mode_usage[i] = '0;
		end else begin
			// Charge elapsed time to the active mode; a backward step charges nothing
			elapsed = longint'(t.now_ms) - longint'(last_tick_ms);
			if (prev_running && elapsed > 0) begin
				sum = longint'(mode_usage[pred_mode]) + elapsed;
				mode_usage[pred_mode] = (sum > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
					: sum[TOTAL_W-1:0];
			end
			last_tick_ms = t.now_ms;
			prev_running = t.live;
		end
		pick = req;
		if (!has_budget(pred_mode)) begin
			// Active mode spent: first mode with budget left, else move; no cooldown
			order[0] = req;
			order[1] = pred_mode;
			order[2] = MODE_MOVE;
			order[3] = MODE_ATTACK;
			order[4] = MODE_DEFEND;
			pick = MODE_MOVE;
			found = 1'b0;
			for (int i = 0; i < 5; i++) begin
				if (!found && has_budget(order[i])) begin
					pick = order[i];
					found = 1'b1;
				end
			end
		end else begin
			if (!has_budget(req))
				pick = pred_mode;
			if (pick != pred_mode) begin
				since = longint'(t.now_ms) - last_switch_ms;
				if (since < longint'(cooldown_cfg))
					pick = pred_mode;
			end
		end
		if (pick != pred_mode) begin
			pred_mode = pick;
			last_switch_ms = longint'(t.now_ms);
		end
		g.granted_mode = pred_mode;
		g.switched = (pred_mode != held);
		return g;
	endfunction

	// Clock: 2 ns period
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Tick driver: hold a word until it is taken, then maybe idle, else offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
			tick_bus.now_ms <= '0;
			tick_bus.want_mode <= '0;
			tick_bus.live <= 1'b0;
		end else begin
			if (tick_bus.valid && tick_bus.ready) begin
				tick_taken = {tick_bus.now_ms, tick_bus.want_mode, tick_bus.live};
				grant_owed.push_back(resolve_tick(tick_taken));
			end
			if (!tick_bus.valid || tick_bus.ready) begin
				if (tick_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					tick_next = tick_pending.pop_front();
					tick_bus.valid <= 1'b1;
					tick_bus.now_ms <= tick_next.now_ms;
					tick_bus.want_mode <= tick_next.want_mode;
					tick_bus.live <= tick_next.live;
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off: count it down one cycle at a time
	always @(posedge clk) begin
		if (arst_n && rx_hold_left > 0)
			rx_hold_left <= rx_hold_left - 1;
	end

	// Grant monitor: check each taken word against the oldest owed grant, then pick ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_bus.ready <= 1'b0;
		end else begin
			if (grant_bus.valid && grant_bus.ready) begin
				if (grant_owed.size() == 0) begin
					$error("grant word with no tick owing it: granted_mode %0d switched %0d",
						grant_bus.granted_mode, grant_bus.switched);
					error_count++;
				end else begin
					grant_due = grant_owed.pop_front();
					if (grant_bus.granted_mode !== grant_due.granted_mode) begin
						$error("granted_mode: expected %0d, actual %0d",
							grant_due.granted_mode, grant_bus.granted_mode);
						error_count++;
					end
					if (grant_bus.switched !== grant_due.switched) begin
						$error("switched: expected %0d, actual %0d",
							grant_due.switched, grant_bus.switched);
						error_count++;
					end
				end
			end
			// A long hold-off takes precedence over the random stall
			if (rx_hold_left > 0)
				grant_bus.ready <= 1'b0;
			else
				grant_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog: end the run if no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_bus.valid && tick_bus.ready) || (grant_bus.valid && grant_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_mode_arbiter_with_cooldown_and_budget_top: errors");
				$finish;
			end
		end
	end

	// Wait until every word has been offered and every grant has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (tick_pending.size() != 0 || tick_bus.valid || grant_owed.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// APB write: setup cycle, access cycle, done at the edge that sees pready
	task automatic write_reg(input reg_idx_t idx, input logic [TOTAL_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_COOLDOWN)
			cooldown_cfg = value;
		else
			limit_cfg = value;
	endtask

	task automatic push_tick(input logic [TIME_W-1:0] now, input logic [MODE_W-1:0] code,
		input logic run);
		tick_word_t w;
		w.now_ms = now;
		w.want_mode = code;
		w.live = run;
		tick_pending.push_back(w);
	endtask

	// Random ticks: mostly forward steps within a running session, with backward
	// steps, wild jumps, repeated stamps and occasional stop/restart of the match
	task automatic queue_random_ticks(input int count, input int unsigned cap);
		int unsigned roll;
		logic [63:0] wide;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 78) begin
				stamp = stamp + $urandom_range(cap);
			end else if (roll < 86) begin
				stamp = stamp - $urandom_range(cap);
			end else if (roll < 91) begin
				wide = {$urandom, $urandom};
				stamp = wide[TIME_W-1:0];
			end
			if (run_flag)
				run_flag = ($urandom_range(99) >= 7);
			else
				run_flag = ($urandom_range(1) == 1);
			push_tick(stamp, MODE_W'($urandom_range(3)), run_flag);
		end
	endtask

	// One phase: program both registers while idle, set idling, play random ticks
	task automatic run_phase(input logic [TOTAL_W-1:0] cooldown, input logic [TOTAL_W-1:0] limit,
		input int unsigned cap, input idle_mode_t idle, input int count, input int hold);
		wait_drained();
		write_reg(REG_COOLDOWN, cooldown);
		write_reg(REG_LIMIT, limit);
		@(negedge clk);
		src_idle_pct = (idle == IDLE_SENDER) ? 72 : (idle == IDLE_BOTH) ? 26 : 0;
		rx_stall_pct = (idle == IDLE_RECEIVER) ? 72 : (idle == IDLE_BOTH) ? 26 : 0;
		queue_random_ticks(count, cap);
		rx_hold_left = hold;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_bus.valid = 1'b0;
		tick_bus.now_ms = '0;
		tick_bus.want_mode = '0;
		tick_bus.live = 1'b0;
		grant_bus.ready = 1'b0;
		src_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_left = 0;
		error_count = 0;
		quiet_cycles = 0;
		stamp = '0;
		run_flag = 1'b1;
		cooldown_cfg = COOLDOWN_RST;
		limit_cfg = LIMIT_RST;
		sess_open = 1'b0;
		prev_running = 1'b0;
		pred_mode = MODE_MOVE;
		last_tick_ms = '0;
		last_switch_ms = 0;
		for (int i = 0; i < NUM_MODES; i++)
			mode_usage[i] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks at the reset settings (cooldown 5000, limit 180000)
		push_tick('0, MODE_MOVE, 1'b0);               // first tick opens a session while stopped
		push_tick(40'd10, MODE_ATTACK, 1'b1);         // match starts: first switch allowed at once
		push_tick(40'd20, MODE_DEFEND, 1'b1);         // inside cooldown: refused
		push_tick(40'd6000, MODE_CODE_SPARE, 1'b1);   // spare code acts as defend
		push_tick(40'd100, MODE_MOVE, 1'b1);          // time runs backwards: no charge, no switch
		push_tick(40'd200100, MODE_ATTACK, 1'b1);     // defend overruns its budget: forced out
		push_tick(40'd200200, MODE_DEFEND, 1'b1);     // request for a spent mode is dropped
		push_tick(40'd200300, MODE_MOVE, 1'b0);       // match stops, last step still charged
		push_tick(40'd300000, MODE_MOVE, 1'b1);       // restart pulls attack back to move
		push_tick(40'd300001, MODE_DEFEND, 1'b1);     // cooldown counts as over after restart
		push_tick(STAMP_MAX, MODE_ATTACK, 1'b1);      // huge step saturates defend's total
		push_tick(STAMP_MAX, MODE_DEFEND, 1'b1);      // zero step, defend still spent
		push_tick('0, MODE_MOVE, 1'b1);               // wrap to zero: negative time since switch
		push_tick(40'd5, MODE_DEFEND, 1'b0);
		push_tick(40'd7, MODE_CODE_SPARE, 1'b1);
		push_tick(40'd8, MODE_ATTACK, 1'b1);
		wait_drained();

		// Random phases through a spread of settings, extremes included
		run_phase(32'd100, 32'd1000, 150, IDLE_NONE, 250, 0);
		run_phase(32'd0, 32'd500, 100, IDLE_SENDER, 250, 0);
		run_phase(32'hFFFF_FFFF, 32'd2000, 300, IDLE_RECEIVER, 250, 0);
		run_phase(32'd50, 32'd0, 40, IDLE_BOTH, 200, 0);
		// Receiver holds off long enough that both result slots fill and tick stalls
		run_phase(32'd200, 32'hFFFF_FFFF, 1000, IDLE_NONE, 250, 80);
		run_phase(32'd20, 32'd300, 60, IDLE_BOTH, 200, 0);
		run_phase(COOLDOWN_RST, LIMIT_RST, 40000, IDLE_SENDER, 200, 0);
		run_phase(32'd1, 32'd1, 3, IDLE_RECEIVER, 200, 0);

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("tb_mode_arbiter_with_cooldown_and_budget_top: clean");
		else
			$display("tb_mode_arbiter_with_cooldown_and_budget_top: errors");
		$finish;
	end

endmodule

/* sim.f */
hdl/mawcb_pkg.sv
hdl/mawcb_tick_if.sv
hdl/mawcb_grant_if.sv
hdl/mode_arbiter_with_cooldown_and_budget_top.sv
bench/tb_mode_arbiter_with_cooldown_and_budget_top.sv
